[sv/ple_pkg.sv]
// Shared types and constants for the positional list engine.
// No dependencies; imported by the top level.
package ple_pkg;

  localparam int unsigned CAPACITY = 16;                         // list slots
  localparam int unsigned AddrW    = $clog2(CAPACITY);           // entry index
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);       // 0..CAPACITY
  localparam int unsigned PosW     = 5;
  localparam int unsigned ValW     = 32;
  localparam int unsigned ActW     = 2;
  localparam int unsigned StatW    = 2;
  localparam int unsigned IdxOutW  = 5;
  localparam int unsigned CntOutW  = 5;
  localparam int unsigned CmpW     = (PosW > CntW) ? PosW : CntW;

  // Slave tdata: position, value, padded to whole bytes
  localparam int unsigned InFieldW = PosW + ValW;
  localparam int unsigned InDataW  = ((InFieldW + 7) / 8) * 8;
  // Master tdata: status, found_index, entry_count, padded to whole bytes
  localparam int unsigned OutFieldW = StatW + IdxOutW + CntOutW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  localparam logic [IdxOutW-1:0] IDX_NONE = '1;  // -1

  typedef enum logic [ActW-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_PUT,
    S_FIND,
    S_RESP
  } state_e;

endpackage

[sv/positional_list_engine.sv]
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit values
// held in a small entry RAM. Each request transfer (tuser = action, tdata = position
// and value) gives exactly one response transfer with status, found index and entry
// count. One request is worked on at a time. The next is taken once the current
// response has been loaded into the output register, so it may start while that
// response still waits there. The entry RAM has one read and one write port, so one
// entry moves or is compared per cycle. With n entries, an insert at position p shifts
// entries p..n-1 up one place, highest first, then writes the new value; a remove
// pulls entries p+1..n-1 down, lowest first; a find compares entries from index 0
// upward until the first match or the end of the list. Rejected requests go
// straight to the response state.
// Depends on ple_pkg and ple_ram.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // [4:0] position, [36:5] value
  input  logic [ActW-1:0]     s_axis_tuser_i,   // [1:0] action
  // Response stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // [1:0] status, [6:2] found_index,
                                                // [11:7] entry_count
);

  // ---------------------------------------------------------------------------
  // Request unpacking
  // ---------------------------------------------------------------------------
  logic [PosW-1:0] in_pos;
  logic [ValW-1:0] in_val;
  logic [ActW-1:0] in_act;

  assign in_pos = s_axis_tdata_i[PosW-1:0];
  assign in_val = s_axis_tdata_i[PosW +: ValW];
  assign in_act = s_axis_tuser_i;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [ValW-1:0]     val_q, val_d;
  logic                ins_q, ins_d;      // walk belongs to an insert (shift up)
  logic [AddrW-1:0]    ptr_q, ptr_d;      // next read address
  logic [CntW-1:0]     left_q, left_d;    // reads still to issue
  logic                pend_q, pend_d;    // read data arrives this cycle
  logic [AddrW-1:0]    wa_q, wa_d;        // write address for pending data / find index
  status_e             res_st_q, res_st_d;
  logic [IdxOutW-1:0]  res_idx_q, res_idx_d;
  logic                out_vld_q, out_vld_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  // RAM port
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [ValW-1:0]  ram_wdata, ram_rdata;

  ple_ram #(
    .Depth (CAPACITY),
    .Width (ValW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Position against count, at a common width
  logic [CmpW-1:0] pos_c, cnt_c;
  assign pos_c = CmpW'(in_pos);
  assign cnt_c = CmpW'(count_q);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pos_d      = pos_q;
    val_d      = val_q;
    ins_d      = ins_q;
    ptr_d      = ptr_q;
    left_d     = left_q;
    pend_d     = 1'b0;
    wa_d       = wa_q;
    res_st_d   = res_st_q;
    res_idx_d  = res_idx_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;

    ram_we    = 1'b0;
    ram_waddr = wa_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr_q;

    // response register drains independently
    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          pos_d     = in_pos;
          val_d     = in_val;
          res_idx_d = IDX_NONE;
          res_st_d  = ST_BADPOS;
          state_d   = S_RESP;
          case (in_act)
            ACT_INSERT: begin
              if (pos_c > cnt_c) begin
                res_st_d = ST_BADPOS;
              end else if (count_q == CntW'(CAPACITY)) begin
                res_st_d = ST_FULL;
              end else begin
                // shift entries p..n-1 up, highest first
                ins_d   = 1'b1;
                ptr_d   = AddrW'(count_q - 1'b1);
                left_d  = CntW'(cnt_c - pos_c);
                state_d = S_MOVE;
              end
            end
            ACT_REMOVE: begin
              if (pos_c >= cnt_c) begin
                res_st_d = ST_BADPOS;
              end else begin
                // pull entries p+1..n-1 down, lowest first
                ins_d   = 1'b0;
                ptr_d   = AddrW'(pos_c + 1'b1);
                left_d  = CntW'(cnt_c - pos_c - 1'b1);
                state_d = S_MOVE;
              end
            end
            ACT_FIND: begin
              ptr_d   = '0;
              left_d  = count_q;
              state_d = S_FIND;
            end
            default: begin
              res_st_d = ST_BADPOS;
            end
          endcase
        end
      end

      S_MOVE: begin
        // read ahead one entry, write back the one read last cycle
        ram_we = pend_q;
        if (left_q != '0) begin
          ram_re = 1'b1;
          pend_d = 1'b1;
          wa_d   = ins_q ? AddrW'(ptr_q + 1'b1) : AddrW'(ptr_q - 1'b1);
          ptr_d  = ins_q ? AddrW'(ptr_q - 1'b1) : AddrW'(ptr_q + 1'b1);
          left_d = CntW'(left_q - 1'b1);
        end else if (ins_q) begin
          state_d = S_PUT;
        end else begin
          count_d  = CntW'(count_q - 1'b1);
          res_st_d = ST_OK;
          state_d  = S_RESP;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AddrW'(pos_q);
        ram_wdata = val_q;
        count_d   = CntW'(count_q + 1'b1);
        res_st_d  = ST_OK;
        state_d   = S_RESP;
      end

      S_FIND: begin
        if (pend_q && (ram_rdata == val_q)) begin
          res_st_d  = ST_OK;
          res_idx_d = IdxOutW'(wa_q);
          state_d   = S_RESP;
        end else if (left_q != '0) begin
          ram_re = 1'b1;
          pend_d = 1'b1;
          wa_d   = ptr_q;
          ptr_d  = AddrW'(ptr_q + 1'b1);
          left_d = CntW'(left_q - 1'b1);
        end else if (!pend_q) begin
          res_st_d  = ST_NOTFOUND;
          res_idx_d = IDX_NONE;
          state_d   = S_RESP;
        end
      end

      S_RESP: begin
        // wait for the output register to be free
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d  = 1'b1;
          out_data_d = OutDataW'({CntOutW'(count_q), res_idx_q, res_st_q});
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    val_q      <= val_d;
    ins_q      <= ins_d;
    ptr_q      <= ptr_d;
    left_q     <= left_d;
    wa_q       <= wa_d;
    res_st_q   <= res_st_d;
    res_idx_q  <= res_idx_d;
    out_data_q <= out_data_d;
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("read and write to the same entry in one cycle");

  a_count_at_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (state_q == S_RESP))
    else $error("entry count changed outside request completion");
`endif

endmodule

[sv/ple_ram.sv]
// Generic simple dual-port RAM: one write and one registered read per cycle.
// No package dependencies.
module ple_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
